### src/lkw_pkg.sv
// Shared types and constants for the link keep-alive watchdog.
package lkw_pkg;

  localparam int unsigned TIME_WIDTH_DEFAULT = 32;
  localparam int unsigned STAMP_W            = 32;
  localparam int unsigned LIMIT_W            = 32;
  localparam int unsigned REQ_W              = 3;

  localparam logic [LIMIT_W-1:0] IDLE_DEFAULT    = LIMIT_W'(3000);
  localparam logic [LIMIT_W-1:0] TIMEOUT_DEFAULT = LIMIT_W'(10000);
  localparam logic [LIMIT_W-1:0] IDLE_MIN        = LIMIT_W'(500);
  localparam logic [LIMIT_W-1:0] TIMEOUT_MIN     = LIMIT_W'(2000);

  typedef enum logic [REQ_W-1:0] {
    REQ_CHECK  = 3'd0,
    REQ_RX     = 3'd1,
    REQ_TX     = 3'd2,
    REQ_TIMING = 3'd3,
    REQ_LINK   = 3'd4
  } req_e_t;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [STAMP_W-1:0] now_ms;
    logic [LIMIT_W-1:0] idle_request_ms;
    logic [LIMIT_W-1:0] timeout_request_ms;
    logic               link_up;
  } event_t;

  typedef struct packed {
    logic send_keepalive;
    logic host_gone;
    logic timing_accepted;
    logic connected_now;
  } result_t;

endpackage

### src/lkw_engine.sv
// Watchdog state and per-event decision logic.
module lkw_engine
  import lkw_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
  input  logic    clk,
  input  logic    rst_n,
  input  event_t  evt,
  input  logic    commit,
  output result_t res
);

  localparam int unsigned CMP_W = (TIME_WIDTH > LIMIT_W) ? TIME_WIDTH : LIMIT_W;

  logic [TIME_WIDTH-1:0] last_rx_r, last_rx_nxt;
  logic [TIME_WIDTH-1:0] last_tx_r, last_tx_nxt;
  logic [LIMIT_W-1:0]    idle_lim_r, idle_lim_nxt;
  logic [LIMIT_W-1:0]    tmo_lim_r, tmo_lim_nxt;
  logic                  host_up_r, host_up_nxt;

  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] rx_elapsed;
  logic [TIME_WIDTH-1:0] tx_elapsed;
  logic                  rx_expired;
  logic                  tx_idle;
  logic                  timing_ok;

  assign now_t      = TIME_WIDTH'(evt.now_ms);
  assign rx_elapsed = now_t - last_rx_r;
  assign tx_elapsed = now_t - last_tx_r;
  assign rx_expired = (last_rx_r != '0) && (CMP_W'(rx_elapsed) >= CMP_W'(tmo_lim_r));
  assign tx_idle    = (last_tx_r == '0) || (CMP_W'(tx_elapsed) >= CMP_W'(idle_lim_r));
  assign timing_ok  = (evt.idle_request_ms >= IDLE_MIN) &&
                      (evt.timeout_request_ms >= TIMEOUT_MIN) &&
                      (evt.timeout_request_ms > evt.idle_request_ms);

  always_comb begin
    last_rx_nxt         = last_rx_r;
    last_tx_nxt         = last_tx_r;
    idle_lim_nxt        = idle_lim_r;
    tmo_lim_nxt         = tmo_lim_r;
    host_up_nxt         = host_up_r;
    res.send_keepalive  = 1'b0;
    res.host_gone       = 1'b0;
    res.timing_accepted = 1'b0;
    case (req_e_t'(evt.req_type))
      REQ_CHECK: begin
        if (host_up_r) begin
          if (rx_expired) begin
            // host silent too long: drop the link and fall back to defaults
            res.host_gone = 1'b1;
            host_up_nxt   = 1'b0;
            idle_lim_nxt  = IDLE_DEFAULT;
            tmo_lim_nxt   = TIMEOUT_DEFAULT;
          end else if (tx_idle) begin
            res.send_keepalive = 1'b1;
            last_tx_nxt        = now_t;
          end
        end
      end
      REQ_RX:  last_rx_nxt = now_t;
      REQ_TX:  last_tx_nxt = now_t;
      REQ_TIMING: begin
        if (timing_ok) begin
          idle_lim_nxt        = evt.idle_request_ms;
          tmo_lim_nxt         = evt.timeout_request_ms;
          res.timing_accepted = 1'b1;
        end
      end
      REQ_LINK: host_up_nxt = evt.link_up;
      default: ;
    endcase
    res.connected_now = host_up_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_rx_r  <= '0;
      last_tx_r  <= '0;
      idle_lim_r <= IDLE_DEFAULT;
      tmo_lim_r  <= TIMEOUT_DEFAULT;
      host_up_r  <= 1'b0;
    end else if (commit) begin
      last_rx_r  <= last_rx_nxt;
      last_tx_r  <= last_tx_nxt;
      idle_lim_r <= idle_lim_nxt;
      tmo_lim_r  <= tmo_lim_nxt;
      host_up_r  <= host_up_nxt;
    end
  end

endmodule

### src/link_keepalive_watchdog.sv
// Top level of the link keep-alive watchdog: input and result registers.
//
// Usage: each transfer on the in_ channel is one link event (periodic check,
// line received, message sent, apply timing, set connection) stamped with a
// free-running millisecond time. Every event yields exactly one result on
// the out_ channel carrying the keep-alive request, host-gone, timing-accepted
// and connection flags. Both channels use valid/ready.
// Path: an event taken on in_ is held in the input register, and its result
// is loaded into the result register before it shows on out_.
// Throughput: one event per cycle while out_ready is high; the event register
// feeds the decision logic and the state and result registers load together,
// so a new event enters while the previous result waits.
// Stall: when out_ready is low with a result held, the result and the event
// behind it hold; in_ready drops only once both registers are full.
// Reset (rst_n low, synchronous): both channels empty, receive and send times
// cleared to never, limits back to 3000 ms idle and 10000 ms timeout, link
// marked disconnected. TIME_WIDTH sets the width of the stored timestamps and
// the wrap of elapsed-time arithmetic.
module link_keepalive_watchdog
  import lkw_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [REQ_W-1:0]   in_req_type,
  input  logic [STAMP_W-1:0] in_now_ms,
  input  logic [LIMIT_W-1:0] in_idle_request_ms,
  input  logic [LIMIT_W-1:0] in_timeout_request_ms,
  input  logic               in_link_up,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_send_keepalive,
  output logic               out_host_gone,
  output logic               out_timing_accepted,
  output logic               out_connected_now
);

  logic    evt_valid_r;
  event_t  evt_r;
  logic    out_valid_r;
  result_t res_r;
  result_t res;
  logic    out_free;
  logic    advance;

  assign out_free = !out_valid_r || out_ready;
  assign advance  = evt_valid_r && out_free;
  assign in_ready = !evt_valid_r || out_free;

  lkw_engine #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .evt   (evt_r),
    .commit(advance),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      evt_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) evt_valid_r <= in_valid;
      if (out_free) out_valid_r <= evt_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      evt_r.req_type           <= in_req_type;
      evt_r.now_ms             <= in_now_ms;
      evt_r.idle_request_ms    <= in_idle_request_ms;
      evt_r.timeout_request_ms <= in_timeout_request_ms;
      evt_r.link_up            <= in_link_up;
    end
    if (advance) res_r <= res;
  end

  assign out_valid           = out_valid_r;
  assign out_send_keepalive  = res_r.send_keepalive;
  assign out_host_gone       = res_r.host_gone;
  assign out_timing_accepted = res_r.timing_accepted;
  assign out_connected_now   = res_r.connected_now;

endmodule

### src/lkw_checker.sv
// Port-level assertions for the link keep-alive watchdog, bound to the top.
module lkw_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_send_keepalive,
  input logic out_host_gone,
  input logic out_timing_accepted,
  input logic out_connected_now
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_send_keepalive) &&
      $stable(out_host_gone) && $stable(out_timing_accepted) &&
      $stable(out_connected_now))
    else $error("result changed while stalled");

  // channel comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // one event raises at most one of the action flags
  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_send_keepalive, out_host_gone, out_timing_accepted}))
    else $error("more than one action flag set");

  // host gone drops the link; a keep-alive only goes out on a live link
  a_gone_link: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_host_gone || out_send_keepalive) |->
      (out_connected_now == out_send_keepalive))
    else $error("connection flag disagrees with check outcome");

endmodule

bind link_keepalive_watchdog lkw_checker u_lkw_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_send_keepalive (out_send_keepalive),
  .out_host_gone      (out_host_gone),
  .out_timing_accepted(out_timing_accepted),
  .out_connected_now  (out_connected_now)
);

### dv/link_keepalive_watchdog_checker.sv
// Result checker for the link keep-alive watchdog: tracks link state and compares every result.
module link_keepalive_watchdog_checker
  import lkw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [REQ_W-1:0]   in_req_type,
  input  logic [STAMP_W-1:0] in_now_ms,
  input  logic [LIMIT_W-1:0] in_idle_request_ms,
  input  logic [LIMIT_W-1:0] in_timeout_request_ms,
  input  logic               in_link_up,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_send_keepalive,
  input  logic               out_host_gone,
  input  logic               out_timing_accepted,
  input  logic               out_connected_now,
  output int                 mismatches,
  output int                 outstanding
);

  result_t            pending_results[$];
  logic [STAMP_W-1:0] last_rx_stamp;
  logic [STAMP_W-1:0] last_tx_stamp;
  logic [LIMIT_W-1:0] idle_lim;
  logic [LIMIT_W-1:0] timeout_lim;
  logic               link_on;
  int                 err_cnt = 0;

  task automatic watchdog_step(input logic [REQ_W-1:0] kind, input logic [STAMP_W-1:0] now,
                               input logic [LIMIT_W-1:0] idle_req,
                               input logic [LIMIT_W-1:0] tmo_req, input logic up_req,
                               output result_t res);
    res = '0;
    case (kind)
      REQ_CHECK: begin
        if (link_on) begin
          // zero stamps mean never, so skip the timeout test until a line arrives
          if (last_rx_stamp != '0 && STAMP_W'(now - last_rx_stamp) >= timeout_lim) begin
            res.host_gone = 1'b1;
            link_on       = 1'b0;
            idle_lim      = IDLE_DEFAULT;
            timeout_lim   = TIMEOUT_DEFAULT;
          end else if (last_tx_stamp == '0 ||
                       STAMP_W'(now - last_tx_stamp) >= idle_lim) begin
            res.send_keepalive = 1'b1;
            last_tx_stamp      = now;
          end
        end
      end
      REQ_RX: last_rx_stamp = now;
      REQ_TX: last_tx_stamp = now;
      REQ_TIMING: begin
        if (idle_req >= IDLE_MIN && tmo_req >= TIMEOUT_MIN && tmo_req > idle_req) begin
          idle_lim            = idle_req;
          timeout_lim         = tmo_req;
          res.timing_accepted = 1'b1;
        end
      end
      REQ_LINK: link_on = up_req;
      default: ;
    endcase
    res.connected_now = link_on;
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst_n) begin
      last_rx_stamp = '0;
      last_tx_stamp = '0;
      idle_lim      = IDLE_DEFAULT;
      timeout_lim   = TIMEOUT_DEFAULT;
      link_on       = 1'b0;
      pending_results.delete();
    end else begin
      // retire first: a result never belongs to an event taken at the same edge
      if (out_valid && out_ready) begin
        got = {out_send_keepalive, out_host_gone, out_timing_accepted, out_connected_now};
        if (pending_results.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: unexpected result keepalive=%0b gone=%0b accepted=%0b conn=%0b",
                     $realtime, got.send_keepalive, got.host_gone, got.timing_accepted,
                     got.connected_now);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display({"%0t: result mismatch keepalive exp %0b got %0b, gone exp %0b got %0b,",
                        " accepted exp %0b got %0b, conn exp %0b got %0b"},
                       $realtime, want.send_keepalive, got.send_keepalive, want.host_gone,
                       got.host_gone, want.timing_accepted, got.timing_accepted,
                       want.connected_now, got.connected_now);
          end
        end
      end
      if (in_valid && in_ready) begin
        watchdog_step(in_req_type, in_now_ms, in_idle_request_ms, in_timeout_request_ms,
                      in_link_up, want);
        pending_results.push_back(want);
      end
    end
    mismatches  <= err_cnt;
    outstanding <= pending_results.size();
  end

endmodule

### dv/link_keepalive_watchdog_tb.sv
// Testbench top for the link keep-alive watchdog: clock, reset, event stimulus and verdict.
module link_keepalive_watchdog_tb;
  import lkw_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [REQ_W-1:0]   in_req_type = '0;
  logic [STAMP_W-1:0] in_now_ms = '0;
  logic [LIMIT_W-1:0] in_idle_request_ms = '0;
  logic [LIMIT_W-1:0] in_timeout_request_ms = '0;
  logic               in_link_up = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_send_keepalive;
  logic               out_host_gone;
  logic               out_timing_accepted;
  logic               out_connected_now;
  int                 mismatches;
  int                 outstanding;

  bit                 tx_calm = 1'b0;
  bit                 rx_calm = 1'b0;
  bit                 hold_off = 1'b0;
  logic [STAMP_W-1:0] stamp = '0;

  link_keepalive_watchdog DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_req_type          (in_req_type),
    .in_now_ms            (in_now_ms),
    .in_idle_request_ms   (in_idle_request_ms),
    .in_timeout_request_ms(in_timeout_request_ms),
    .in_link_up           (in_link_up),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_send_keepalive   (out_send_keepalive),
    .out_host_gone        (out_host_gone),
    .out_timing_accepted  (out_timing_accepted),
    .out_connected_now    (out_connected_now)
  );

  link_keepalive_watchdog_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_req_type          (in_req_type),
    .in_now_ms            (in_now_ms),
    .in_idle_request_ms   (in_idle_request_ms),
    .in_timeout_request_ms(in_timeout_request_ms),
    .in_link_up           (in_link_up),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_send_keepalive   (out_send_keepalive),
    .out_host_gone        (out_host_gone),
    .out_timing_accepted  (out_timing_accepted),
    .out_connected_now    (out_connected_now),
    .mismatches           (mismatches),
    .outstanding          (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int pick_gap(bit calm);
    return calm ? 0 : int'($urandom_range(0, 14));
  endfunction

  // Keep valid high across back-to-back transfers; lower it only ahead of a gap.
  task automatic send_event(input logic [REQ_W-1:0] kind, input logic [STAMP_W-1:0] now,
                            input logic [LIMIT_W-1:0] idle_req,
                            input logic [LIMIT_W-1:0] tmo_req, input logic up, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid              <= 1'b1;
    in_req_type           <= kind;
    in_now_ms             <= now;
    in_idle_request_ms    <= idle_req;
    in_timeout_request_ms <= tmo_req;
    in_link_up            <= up;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic send_random_event(input int gap);
    int                 pick;
    logic [REQ_W-1:0]   kind;
    logic [LIMIT_W-1:0] idle_req;
    logic [LIMIT_W-1:0] tmo_req;
    pick = $urandom_range(0, 99);
    if (pick < 70)      stamp = stamp + $urandom_range(0, 1500);
    else if (pick < 90) stamp = stamp + $urandom_range(1500, 12000);
    else if (pick < 98) stamp = $urandom();
    else                stamp = '0;
    idle_req = $urandom();
    tmo_req  = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 38)      kind = REQ_CHECK;
    else if (pick < 55) kind = REQ_RX;
    else if (pick < 67) kind = REQ_TX;
    else if (pick < 80) kind = REQ_TIMING;
    else if (pick < 95) kind = REQ_LINK;
    else                kind = REQ_W'($urandom_range(REQ_LINK + 1, (1 << REQ_W) - 1));
    if (kind == REQ_TIMING) begin
      pick = $urandom_range(0, 3);
      if (pick < 2) begin
        idle_req = $urandom_range(400, 6000);
        tmo_req  = idle_req + $urandom_range(0, 20000) - 1000;
      end else if (pick == 2) begin
        idle_req = IDLE_MIN + $urandom_range(0, 2) - 1;
        case ($urandom_range(0, 4))
          0:       tmo_req = TIMEOUT_MIN - 1;
          1:       tmo_req = TIMEOUT_MIN;
          2:       tmo_req = TIMEOUT_MIN + 1;
          3:       tmo_req = idle_req;
          default: tmo_req = idle_req + 1;
        endcase
      end
    end
    // favor connected so that checks reach the keep-alive and timeout paths
    send_event(kind, stamp, idle_req, tmo_req, $urandom_range(0, 99) < 85, gap);
  endtask

  // result side: per-result stall, calm stretches, and one long hold-off on request
  initial begin
    int rx_count;
    int wait_cycles;
    bit hold_done;
    rx_count  = 0;
    hold_done = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off && !hold_done) begin
        out_ready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_done = 1'b1;
      end
      wait_cycles = pick_gap(rx_calm);
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      rx_count++;
      if (rx_count % 110 == 0) rx_calm = ~rx_calm;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: disconnected check, timing validation edges, never-sent and
    // never-received stamps, wrap of elapsed time, host loss, spare codes
    send_event(REQ_CHECK, 32'd100, '0, '0, 1'b0, pick_gap(tx_calm));
    send_event(REQ_TIMING, 32'd0, IDLE_MIN - 1, TIMEOUT_MIN, 1'b0, pick_gap(tx_calm));
    send_event(REQ_TIMING, 32'd0, IDLE_MIN, TIMEOUT_MIN - 1, 1'b0, pick_gap(tx_calm));
    send_event(REQ_TIMING, 32'd0, TIMEOUT_MIN, TIMEOUT_MIN, 1'b0, pick_gap(tx_calm));
    send_event(REQ_TIMING, '1, '1, '1, 1'b1, pick_gap(tx_calm));
    send_event(REQ_TIMING, 32'd0, '0, '1, 1'b0, pick_gap(tx_calm));
    send_event(REQ_TIMING, 32'd0, IDLE_MIN, TIMEOUT_MIN, 1'b0, pick_gap(tx_calm));
    send_event(REQ_LINK, 32'd0, '1, '1, 1'b1, pick_gap(tx_calm));
    send_event(REQ_CHECK, 32'd0, '0, '0, 1'b0, pick_gap(tx_calm));
    send_event(REQ_CHECK, 32'd10, '0, '0, 1'b0, pick_gap(tx_calm));
    send_event(REQ_CHECK, 32'd509, '0, '0, 1'b0, pick_gap(tx_calm));
    send_event(REQ_RX, 32'd0, '0, '0, 1'b0, pick_gap(tx_calm));
    send_event(REQ_CHECK, 32'd510, '0, '0, 1'b0, pick_gap(tx_calm));
    send_event(REQ_RX, 32'hFFFF_FF00, '0, '0, 1'b0, pick_gap(tx_calm));
    send_event(REQ_TX, 32'hFFFF_FF00, '0, '0, 1'b0, pick_gap(tx_calm));
    send_event(REQ_CHECK, 32'h0000_0100, '0, '0, 1'b0, pick_gap(tx_calm));
    send_event(REQ_TIMING, 32'd0, IDLE_DEFAULT, TIMEOUT_DEFAULT, 1'b0, pick_gap(tx_calm));
    send_event(REQ_CHECK, 32'hFFFF_FF00 + 32'd9999, '0, '0, 1'b0, pick_gap(tx_calm));
    send_event(REQ_CHECK, 32'hFFFF_FF00 + 32'd10000, '0, '0, 1'b0, pick_gap(tx_calm));
    send_event(REQ_CHECK, 32'hFFFF_FF00 + 32'd10000, '0, '0, 1'b0, pick_gap(tx_calm));
    for (int k = REQ_LINK + 1; k < (1 << REQ_W); k++)
      send_event(REQ_W'(k), $urandom(), $urandom(), $urandom(), 1'b1, pick_gap(tx_calm));
    send_event(REQ_LINK, '1, '0, '0, 1'b0, pick_gap(tx_calm));
    send_event(REQ_TIMING, 32'd0, '1 - 1, '1, 1'b0, pick_gap(tx_calm));
    drain_results();

    for (int n = 0; n < 1280; n++) begin
      if (n % 100 == 0) tx_calm = ~tx_calm;
      if (n == 300 || n == 850) drain_results();
      if (n == 500) begin
        // stall the result side while events keep coming back to back
        hold_off = 1'b1;
        repeat (20) send_random_event(0);
      end
      send_random_event(pick_gap(tx_calm));
    end
    drain_results();
    repeat (4) @(posedge clk);

    if (mismatches == 0 && outstanding == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
